### rtl/core/mdmac_pkg.sv
// ----------------------------------------------------------------------------
// mdmac_pkg
// Shared types and register map of the multiply / divide / accumulate unit.
// ----------------------------------------------------------------------------
package mdmac_pkg;

  // bus register map
  localparam logic [15:0] ADDR_MODE = 16'h2250;
  localparam logic [15:0] ADDR_A_LO = 16'h2251;
  localparam logic [15:0] ADDR_A_HI = 16'h2252;
  localparam logic [15:0] ADDR_B_LO = 16'h2253;
  localparam logic [15:0] ADDR_B_HI = 16'h2254;
  localparam logic [15:0] ADDR_RES0 = 16'h2306;
  localparam logic [15:0] ADDR_RES1 = 16'h2307;
  localparam logic [15:0] ADDR_RES2 = 16'h2308;
  localparam logic [15:0] ADDR_RES3 = 16'h2309;
  localparam logic [15:0] ADDR_RES4 = 16'h230a;
  localparam logic [15:0] ADDR_OVF  = 16'h230b;

  // mode register bits
  localparam int unsigned MODE_DIV_BIT = 0;
  localparam int unsigned MODE_SUM_BIT = 1;

  // serial engine states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } mdmac_state_t;

  // start request to the serial engine
  typedef struct packed {
    logic        start;
    logic [15:0] a;
    logic [15:0] b;
  } mdmac_req_t;

  // engine status and results
  typedef struct packed {
    logic        busy;
    logic        done;
    logic        div_zero;
    logic [31:0] product;
    logic [15:0] quotient;
    logic [15:0] remainder;
  } mdmac_rsp_t;

endpackage

### rtl/core/mdmac_serial.sv
// ----------------------------------------------------------------------------
// mdmac_serial
// Bit-serial engine: signed shift-add multiply and restoring divide of a
// signed dividend by an unsigned divisor, one bit of each per cycle.
// ----------------------------------------------------------------------------
module mdmac_serial (
  input  logic                clk,
  input  logic                rst_n,
  input  mdmac_pkg::mdmac_req_t req,
  output mdmac_pkg::mdmac_rsp_t rsp
);
  import mdmac_pkg::*;

  mdmac_state_t state_r, state_nxt;
  logic [3:0]   count_r, count_nxt;

  // multiply datapath
  logic [31:0]  acc_r, acc_nxt;
  logic [31:0]  mcand_r, mcand_nxt;
  logic [15:0]  mplier_r, mplier_nxt;

  // divide datapath
  logic [15:0]  rem_r, rem_nxt;
  logic [15:0]  quo_r, quo_nxt;
  logic [15:0]  den_r, den_nxt;
  logic         neg_r, neg_nxt;

  logic         last_step;
  logic [31:0]  addend;
  logic [17:0]  trial;

  assign last_step = (count_r == 4'hf);
  // top bit of the multiplier carries negative weight
  assign addend    = last_step ? (~mcand_r + 32'd1) : mcand_r;
  assign trial     = {1'b0, rem_r, quo_r[15]} - {2'b00, den_r};

  // next state and datapath steps
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    den_nxt    = den_r;
    neg_nxt    = neg_r;
    case (state_r)
      ST_IDLE: begin
        if (req.start) begin
          state_nxt  = ST_RUN;
          count_nxt  = 4'd0;
          acc_nxt    = 32'd0;
          mcand_nxt  = {{16{req.a[15]}}, req.a};
          mplier_nxt = req.b;
          rem_nxt    = 16'd0;
          quo_nxt    = req.a[15] ? (~req.a + 16'd1) : req.a;
          den_nxt    = req.b;
          neg_nxt    = req.a[15];
        end
      end
      ST_RUN: begin
        // one multiplier bit
        if (mplier_r[0]) begin
          acc_nxt = acc_r + addend;
        end
        mcand_nxt  = {mcand_r[30:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[15:1]};
        // one quotient bit
        if (!trial[17]) begin
          rem_nxt = trial[15:0];
          quo_nxt = {quo_r[14:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[14:0], quo_r[15]};
          quo_nxt = {quo_r[14:0], 1'b0};
        end
        count_nxt = count_r + 4'd1;
        if (last_step) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= 4'd0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    den_r    <= den_nxt;
    neg_r    <= neg_nxt;
  end

  // results, sign restored on quotient and remainder
  always_comb begin
    rsp.busy      = (state_r != ST_IDLE);
    rsp.done      = (state_r == ST_DONE);
    rsp.div_zero  = (den_r == 16'd0);
    rsp.product   = acc_r;
    rsp.quotient  = neg_r ? (~quo_r + 16'd1) : quo_r;
    rsp.remainder = neg_r ? (~rem_r + 16'd1) : rem_r;
  end

endmodule

### rtl/core/mul_div_mac_register_unit_core.sv
// ----------------------------------------------------------------------------
// mul_div_mac_register_unit_core
// Byte-wide register front end of the multiply / divide / accumulate unit.
// ----------------------------------------------------------------------------
// Each request is one bus access and yields one response byte (zero for
// writes). A write to the high byte of operand B starts an operation in the
// bit-serial engine: shift-add multiply or restoring divide, then a step
// that writes the result; no request is taken until the engine is idle
// again. The response register takes a new request in the same cycle that
// the previous response leaves, so a stalled response holds back the next
// request.
module mul_div_mac_register_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] reg_address, [23:16] write_data
  input  logic        in_tuser,   // [0] action (1 write, 0 read)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [7:0] read_data
);
  import mdmac_pkg::*;

  logic [15:0] operand_a_r, operand_a_nxt;
  logic [15:0] operand_b_r, operand_b_nxt;
  logic [39:0] result_r, result_nxt;
  logic        ovf_r, ovf_nxt;
  logic        sum_mode_r, sum_mode_nxt;
  logic        div_mode_r, div_mode_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r, out_data_nxt;

  logic [15:0] addr;
  logic [7:0]  wdata;
  logic        accept;
  logic [7:0]  rd_byte;
  logic [41:0] sum_ext;

  mdmac_req_t eng_req;
  mdmac_rsp_t eng_rsp;

  assign addr      = in_tdata[15:0];
  assign wdata     = in_tdata[23:16];
  assign in_tready = !eng_rsp.busy && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // serial multiply / divide engine
  mdmac_serial u_serial (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (eng_req),
    .rsp   (eng_rsp)
  );

  always_comb begin
    eng_req.start = accept && in_tuser && (addr == ADDR_B_HI);
    eng_req.a     = operand_a_r;
    eng_req.b     = {wdata, operand_b_r[7:0]};
  end

  // accumulate with carry or borrow out of 40 bits
  assign sum_ext = {2'b00, result_r} + {{10{eng_rsp.product[31]}}, eng_rsp.product};

  // read byte select
  always_comb begin
    case (addr)
      ADDR_RES0: rd_byte = result_r[7:0];
      ADDR_RES1: rd_byte = result_r[15:8];
      ADDR_RES2: rd_byte = result_r[23:16];
      ADDR_RES3: rd_byte = result_r[31:24];
      ADDR_RES4: rd_byte = result_r[39:32];
      ADDR_OVF:  rd_byte = {ovf_r, 7'd0};
      default:   rd_byte = 8'd0;
    endcase
  end

  // register writes and result commit
  always_comb begin
    operand_a_nxt = operand_a_r;
    operand_b_nxt = operand_b_r;
    result_nxt    = result_r;
    ovf_nxt       = ovf_r;
    sum_mode_nxt  = sum_mode_r;
    div_mode_nxt  = div_mode_r;
    if (accept && in_tuser) begin
      case (addr)
        ADDR_MODE: begin
          sum_mode_nxt = wdata[MODE_SUM_BIT];
          div_mode_nxt = wdata[MODE_DIV_BIT];
          if (wdata[MODE_SUM_BIT]) begin
            result_nxt = 40'd0;
          end
        end
        ADDR_A_LO: operand_a_nxt = {operand_a_r[15:8], wdata};
        ADDR_A_HI: operand_a_nxt = {wdata, operand_a_r[7:0]};
        ADDR_B_LO: operand_b_nxt = {operand_b_r[15:8], wdata};
        ADDR_B_HI: operand_b_nxt = {wdata, operand_b_r[7:0]};
        default: begin
        end
      endcase
    end
    if (eng_rsp.done) begin
      operand_b_nxt = 16'd0;
      if (sum_mode_r) begin
        result_nxt = sum_ext[39:0];
        ovf_nxt    = sum_ext[41] | sum_ext[40];
      end else if (div_mode_r) begin
        operand_a_nxt = 16'd0;
        result_nxt    = eng_rsp.div_zero ? 40'd0
                      : {8'd0, eng_rsp.remainder, eng_rsp.quotient};
      end else begin
        result_nxt = {{8{eng_rsp.product[31]}}, eng_rsp.product};
      end
    end
  end

  // response register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = in_tuser ? 8'd0 : rd_byte;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      operand_a_r <= 16'd0;
      operand_b_r <= 16'd0;
      result_r    <= 40'd0;
      ovf_r       <= 1'b0;
      sum_mode_r  <= 1'b0;
      div_mode_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      operand_a_r <= operand_a_nxt;
      operand_b_r <= operand_b_nxt;
      result_r    <= result_nxt;
      ovf_r       <= ovf_nxt;
      sum_mode_r  <= sum_mode_nxt;
      div_mode_r  <= div_mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/core/mdmac_chk.sv
// ----------------------------------------------------------------------------
// mdmac_chk
// Port-level checks on the multiply / divide / accumulate unit, bound in.
// ----------------------------------------------------------------------------
module mdmac_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);
  import mdmac_pkg::*;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("response changed while stalled");

  // writes answer with zero
  a_wr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser |=> out_tvalid && (out_tdata == 8'd0))
    else $error("write response not zero");

  // trigger write occupies the engine
  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser && (in_tdata[15:0] == ADDR_B_HI) |=> !in_tready)
    else $error("request taken while operation running");

  // overflow read carries only the flag bit
  a_ovf_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_tuser && (in_tdata[15:0] == ADDR_OVF) |=> out_tdata[6:0] == 7'd0)
    else $error("overflow read has stray bits");

  // reset empties the response slot
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("response valid after reset");

endmodule

bind mul_div_mac_register_unit_core mdmac_chk u_mdmac_chk (.*);

### test/mul_div_mac_register_unit_core_tb.sv
// ----------------------------------------------------------------------------
// mul_div_mac_register_unit_core_tb
// Drives byte-wide bus requests into the multiply / divide / accumulate unit
// and checks every response byte against a built-in model or a table entry.
// A short table of directed requests comes first, then random operand load and
// trigger sequences mixed with stray accesses, under changing idle and stall
// patterns on both stream sides.
// ----------------------------------------------------------------------------
module mul_div_mac_register_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mdmac_pkg::*;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int N_DIRECTED    = 25;
  localparam int RANDOM_ITEMS  = 1425;
  localparam int DRAIN_CYCLES  = 40;

  // one row of the directed request table
  typedef struct packed {
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  wdat;
    logic        known;
    logic [7:0]  rd;
  } access_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [15:0] reg_address, [23:16] write_data
  logic        in_tuser = 1'b0; // [0] action (1 write, 0 read)
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] read_data

  // model of the unit's registers
  logic [15:0] m_a = '0;
  logic [15:0] m_b = '0;
  logic [39:0] m_acc = '0;
  logic        m_ovf = 1'b0;
  logic        m_sum = 1'b0;
  logic        m_div = 1'b0;

  logic [7:0]  exp_bytes [$];
  logic [7:0]  want_byte;
  int          error_count = 0;
  int          sent_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  access_row_t directed_rows [N_DIRECTED];

  mul_div_mac_register_unit_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    error_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // applies one bus access to the model and returns the byte it should read
  function automatic logic [7:0] predict_read_byte(logic wr, logic [15:0] addr,
                                                   logic [7:0] wdat);
    logic [7:0]         rd;
    logic signed [15:0] sa;
    logic signed [15:0] sb;
    logic signed [31:0] prod;
    logic [63:0]        sum64;
    int                 num;
    int                 den;
    int                 quo;
    int                 rem;
    int unsigned        sh;
    rd = '0;
    if (wr) begin
      case (addr)
        ADDR_MODE: begin
          m_sum = wdat[MODE_SUM_BIT];
          m_div = wdat[MODE_DIV_BIT];
          if (m_sum) m_acc = '0;
        end
        ADDR_A_LO: m_a[7:0] = wdat;
        ADDR_A_HI: m_a[15:8] = wdat;
        ADDR_B_LO: m_b[7:0] = wdat;
        ADDR_B_HI: begin
          m_b[15:8] = wdat;
          sa = m_a;
          sb = m_b;
          prod = sa * sb;
          if (m_sum) begin
            // accumulate, carry or borrow out of 40 bits sets the flag
            sum64 = {24'b0, m_acc} + {{32{prod[31]}}, prod};
            m_ovf = |sum64[63:40];
            m_acc = sum64[39:0];
            m_b = '0;
          end else if (!m_div) begin
            m_acc = {{8{prod[31]}}, prod};
            m_b = '0;
          end else begin
            // signed dividend over unsigned divisor, truncated
            if (m_b == '0) begin
              m_acc = '0;
            end else begin
              num = sa;
              den = int'({16'b0, m_b});
              quo = num / den;
              rem = num % den;
              m_acc = {8'b0, rem[15:0], quo[15:0]};
            end
            m_a = '0;
            m_b = '0;
          end
        end
        default: ;
      endcase
    end else begin
      if (addr >= ADDR_RES0 && addr <= ADDR_RES4) begin
        sh = 32'(addr - ADDR_RES0) * 8;
        rd = 8'(m_acc >> sh);
      end else if (addr == ADDR_OVF) begin
        rd = {m_ovf, 7'b0};
      end
    end
    return rd;
  endfunction

  // issues one request, records the expected response once it is taken
  task automatic send_access(logic wr, logic [15:0] addr, logic [7:0] wdat,
                             logic known, logic [7:0] known_rd);
    logic [7:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {wdat, addr};
    in_tuser  <= wr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_read_byte(wr, addr, wdat);
    exp_bytes.push_back(known ? known_rd : predicted);
    sent_count++;
    @(negedge clk);
  endtask

  // operand bytes biased towards the signed extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h80;
      3: return 8'h7f;
      4: return 8'h01;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one random sequence: mostly a mode write, operand loads and reads back
  task automatic run_random_sequence();
    logic [7:0]  mode_byte;
    logic [15:0] stray_addr;
    int          n_ops;
    if ($urandom_range(99) < 20) begin
      // stray accesses anywhere on the bus
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(3))
          0: stray_addr = 16'($urandom_range(16'hffff));
          1: stray_addr = ADDR_MODE - 16'd8 + 16'($urandom_range(16));
          2: stray_addr = ADDR_RES0 - 16'd4 + 16'($urandom_range(12));
          default: stray_addr = ($urandom_range(1)) ? ADDR_MODE + 16'($urandom_range(4))
                                                  : ADDR_RES0 + 16'($urandom_range(5));
        endcase
        send_access(1'($urandom_range(1)), stray_addr, 8'($urandom_range(255)), 1'b0, '0);
      end
    end else begin
      mode_byte = 8'($urandom_range(255));
      if ($urandom_range(99) < 85) send_access(1'b1, ADDR_MODE, mode_byte, 1'b0, '0);
      n_ops = mode_byte[MODE_SUM_BIT] ? $urandom_range(1, 6) : 1;
      repeat (n_ops) begin
        if ($urandom_range(99) < 85) send_access(1'b1, ADDR_A_LO, pick_byte(), 1'b0, '0);
        if ($urandom_range(99) < 85) send_access(1'b1, ADDR_A_HI, pick_byte(), 1'b0, '0);
        if ($urandom_range(99) < 85) send_access(1'b1, ADDR_B_LO, pick_byte(), 1'b0, '0);
        if ($urandom_range(99) < 10)
          send_access(1'b0, ADDR_RES0 + 16'($urandom_range(5)), 8'($urandom_range(255)),
                      1'b0, '0);
        send_access(1'b1, ADDR_B_HI, pick_byte(), 1'b0, '0);
      end
      repeat ($urandom_range(1, 6))
        send_access(1'b0, ADDR_RES0 + 16'($urandom_range(5)), 8'($urandom_range(255)),
                    1'b0, '0);
    end
  endtask

  // response side back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // response checking
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_bytes.size() == 0) begin
        report_mismatch($sformatf("response %02h with no request waiting", out_tdata));
      end else begin
        want_byte = exp_bytes.pop_front();
        if (out_tdata !== want_byte)
          report_mismatch($sformatf("read_data %02h, expected %02h", out_tdata, want_byte));
      end
    end
  end

  // main sequence
  initial begin
    int phase_end;

    // reset values, extremes, zero divisor, sum borrow and unmapped accesses
    directed_rows = '{
      '{1'b0, ADDR_RES0,  8'h00, 1'b1, 8'h00},
      '{1'b0, ADDR_OVF,   8'h00, 1'b1, 8'h00},
      '{1'b1, ADDR_MODE,  8'h00, 1'b0, 8'h00},
      '{1'b1, ADDR_A_LO,  8'h00, 1'b0, 8'h00},
      '{1'b1, ADDR_A_HI,  8'h80, 1'b0, 8'h00},
      '{1'b1, ADDR_B_LO,  8'h00, 1'b0, 8'h00},
      '{1'b1, ADDR_B_HI,  8'h80, 1'b0, 8'h00},
      '{1'b0, ADDR_RES3,  8'h00, 1'b1, 8'h40},
      '{1'b1, ADDR_MODE,  8'h01, 1'b0, 8'h00},
      '{1'b1, ADDR_A_LO,  8'h00, 1'b0, 8'h00},
      '{1'b1, ADDR_A_HI,  8'h80, 1'b0, 8'h00},
      '{1'b1, ADDR_B_HI,  8'hff, 1'b0, 8'h00},
      '{1'b0, ADDR_RES2,  8'h00, 1'b0, 8'h00},
      '{1'b0, ADDR_RES3,  8'h00, 1'b0, 8'h00},
      '{1'b1, ADDR_A_LO,  8'h05, 1'b0, 8'h00},
      '{1'b1, ADDR_B_HI,  8'h00, 1'b0, 8'h00},
      '{1'b0, ADDR_RES2,  8'h00, 1'b1, 8'h00},
      '{1'b1, ADDR_MODE,  8'hfe, 1'b0, 8'h00},
      '{1'b1, ADDR_A_LO,  8'h01, 1'b0, 8'h00},
      '{1'b1, ADDR_B_LO,  8'hff, 1'b0, 8'h00},
      '{1'b1, ADDR_B_HI,  8'hff, 1'b0, 8'h00},
      '{1'b0, ADDR_OVF,   8'h00, 1'b1, 8'h80},
      '{1'b0, ADDR_RES4,  8'h00, 1'b1, 8'hff},
      '{1'b1, 16'hffff,   8'hff, 1'b0, 8'h00},
      '{1'b0, 16'h0000,   8'h00, 1'b1, 8'h00}
    };

    // hold synchronous reset, then release it
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed requests, with light idling
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    foreach (directed_rows[i])
      send_access(directed_rows[i].wr, directed_rows[i].addr, directed_rows[i].wdat,
                  directed_rows[i].known, directed_rows[i].rd);

    // random requests in four idling phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      phase_end = N_DIRECTED + (RANDOM_ITEMS * (phase + 1)) / 4;
      while (sent_count < phase_end) run_random_sequence();
    end
    in_tvalid <= 1'b0;

    // drain outstanding responses
    while (exp_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
